// ===== design/tsp_pkg.sv =====
`default_nettype none

package tsp_pkg;

  localparam int unsigned STEP_WIDTH      = 7;
  localparam int unsigned VALUE_WIDTH     = 14;
  localparam int unsigned TICKS_WIDTH     = 16;
  localparam int unsigned TEMP_WIDTH      = 14;
  localparam int unsigned OP_WIDTH        = 2;
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 16;
  localparam int unsigned SEL_WIDTH       = 3;
  localparam int unsigned DATA_WIDTH      = 8;

  localparam int unsigned DIGIT_COUNT     = 4;
  localparam int unsigned DIGIT_IDX_WIDTH = $clog2(DIGIT_COUNT);
  localparam int unsigned POINT_DIGIT     = 3;
  localparam logic [DATA_WIDTH-1:0] POINT_BIT = 8'h80;

  localparam int unsigned SET_POINT_RESET     = 236;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [STEP_WIDTH-1:0]  STEP_SIZE_RESET = 7'd10;
  localparam logic [VALUE_WIDTH-1:0] LIMIT_RESET     = 14'd1000;
  localparam logic [TICKS_WIDTH-1:0] TICKS_RESET     = 16'd5000;

  // Exact reciprocals for any 14-bit value: floor(v * MULT / 2**SHIFT) == v / divisor.
  localparam logic [31:0] DIV1000_MULT  = 32'd16778;
  localparam int unsigned DIV1000_SHIFT = 24;
  localparam logic [31:0] DIV100_MULT   = 32'd20972;
  localparam int unsigned DIV100_SHIFT  = 21;
  localparam logic [31:0] DIV10_MULT    = 32'd13108;
  localparam int unsigned DIV10_SHIFT   = 17;

  localparam int unsigned Q1000_WIDTH = 5;
  localparam int unsigned Q100_WIDTH  = 8;
  localparam int unsigned Q10_WIDTH   = 11;

  localparam logic [OP_WIDTH-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_BUTTON  = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_ENCODER = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_SIZE       = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SET_POINT_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS  = 2'd2;

  typedef struct packed {
    logic                   display;
    logic [VALUE_WIDTH-1:0] value;
    logic                   heater;
    logic                   edit;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/tsp_front.sv =====
`default_nettype none

module tsp_front #(
  parameter int unsigned INITIAL_SET_POINT = tsp_pkg::SET_POINT_RESET
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tsp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [tsp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tsp_pkg::OP_WIDTH-1:0]         operation,
  input  logic                                 button_low,
  input  logic                                 encoder_a_low,
  input  logic                                 encoder_b_low,
  input  logic [tsp_pkg::TEMP_WIDTH-1:0]       temperature,
  output logic                                 push,
  output tsp_pkg::entry_t                      push_entry,
  input  logic                                 queue_full
);
  import tsp_pkg::*;

  logic [STEP_WIDTH-1:0]  step_size;
  logic [VALUE_WIDTH-1:0] set_point_limit;
  logic [TICKS_WIDTH-1:0] debounce_ticks;

  logic [VALUE_WIDTH-1:0] target_value, target_value_next;
  logic                   edit_mode, edit_mode_next;
  logic [TICKS_WIDTH-1:0] debounce_count, debounce_count_next;
  logic                   debounce_busy, debounce_busy_next;
  logic                   heater_state, heater_state_next;

  logic                   accept;
  logic                   display;
  logic [VALUE_WIDTH:0]   sum_up;
  logic [VALUE_WIDTH-1:0] step_ext;
  logic [VALUE_WIDTH-1:0] moved;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign step_ext = {{(VALUE_WIDTH - STEP_WIDTH){1'b0}}, step_size};
  assign sum_up   = {1'b0, target_value} + {1'b0, step_ext};

  always_comb begin
    moved = target_value;
    if (encoder_a_low) begin
      moved = (target_value > step_ext) ? target_value - step_ext : '0;
    end else if (encoder_b_low) begin
      moved = (sum_up > {1'b0, set_point_limit}) ? set_point_limit
                                                 : sum_up[VALUE_WIDTH-1:0];
    end
  end

  always_comb begin
    target_value_next   = target_value;
    edit_mode_next      = edit_mode;
    debounce_count_next = debounce_count;
    debounce_busy_next  = debounce_busy;
    heater_state_next   = heater_state;
    display             = 1'b0;
    case (operation)
      OP_TICK: begin
        if (debounce_busy) begin
          if (debounce_count <= TICKS_WIDTH'(1)) begin
            debounce_count_next = '0;
            debounce_busy_next  = 1'b0;
            if (button_low) begin
              edit_mode_next    = !edit_mode;
              heater_state_next = edit_mode ? (temperature < target_value) : 1'b0;
            end
          end else begin
            debounce_count_next = debounce_count - TICKS_WIDTH'(1);
          end
        end
      end
      OP_BUTTON: begin
        if (!debounce_busy) begin
          debounce_busy_next  = 1'b1;
          debounce_count_next = debounce_ticks;
          display             = 1'b1;
        end
      end
      OP_ENCODER: begin
        if (edit_mode) begin
          target_value_next = moved;
        end
        display = 1'b1;
      end
      default: begin
      end
    endcase
    if (display && (target_value_next > set_point_limit)) begin
      target_value_next = set_point_limit;
    end
  end

  assign push               = accept;
  assign push_entry.display = display;
  assign push_entry.value   = target_value_next;
  assign push_entry.heater  = heater_state_next;
  assign push_entry.edit    = edit_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= STEP_SIZE_RESET;
      set_point_limit <= LIMIT_RESET;
      debounce_ticks  <= TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_SIZE:       step_size       <= cfg_data[STEP_WIDTH-1:0];
        REG_SET_POINT_LIMIT: set_point_limit <= cfg_data[VALUE_WIDTH-1:0];
        REG_DEBOUNCE_TICKS:  debounce_ticks  <= cfg_data[TICKS_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_value   <= VALUE_WIDTH'(INITIAL_SET_POINT);
      edit_mode      <= 1'b0;
      debounce_count <= '0;
      debounce_busy  <= 1'b0;
      heater_state   <= 1'b0;
    end else if (accept) begin
      target_value   <= target_value_next;
      edit_mode      <= edit_mode_next;
      debounce_count <= debounce_count_next;
      debounce_busy  <= debounce_busy_next;
      heater_state   <= heater_state_next;
    end
  end

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !debounce_busy |-> (debounce_count == '0))
    else $error("Debounce count is nonzero while no countdown runs.");

  a_edit_heater_off: assert property (@(posedge clk) disable iff (rst)
    edit_mode |-> !heater_state)
    else $error("Heater is on in edit mode.");

endmodule

`default_nettype wire

// ===== design/tsp_queue.sv =====
`default_nettype none

module tsp_queue #(
  parameter int unsigned DEPTH = tsp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tsp_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output tsp_pkg::entry_t pop_entry,
  output logic            empty
);
  import tsp_pkg::*;

  localparam int unsigned IndexWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountWidth = $clog2(DEPTH + 1);

  entry_t                slots [DEPTH];
  logic [IndexWidth-1:0] head;
  logic [IndexWidth-1:0] tail;
  logic [CountWidth-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (count == CountWidth'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == IndexWidth'(DEPTH - 1)) ? '0 : tail + IndexWidth'(1);
      end
      if (do_pop) begin
        head <= (head == IndexWidth'(DEPTH - 1)) ? '0 : head + IndexWidth'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CountWidth'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CountWidth'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountWidth'(DEPTH))
    else $error("Queue count exceeds its depth.");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("Word popped from an empty queue.");

endmodule

`default_nettype wire

// ===== design/tsp_back.sv =====
`default_nettype none

module tsp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  tsp_pkg::entry_t                 pop_entry,
  input  logic                            queue_empty,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            word_valid,
  output logic [tsp_pkg::SEL_WIDTH-1:0]   digit_select,
  output logic [tsp_pkg::DATA_WIDTH-1:0]  digit_data,
  output logic                            heater_on,
  output logic                            edit_lamp,
  output logic                            last_word
);
  import tsp_pkg::*;

  entry_t                     conv_entry;
  logic                       conv_valid;
  logic [Q1000_WIDTH-1:0]     q1000;
  logic [Q100_WIDTH-1:0]      q100;
  logic [Q10_WIDTH-1:0]       q10;
  logic [DIGIT_IDX_WIDTH-1:0] idx;

  logic [31:0]                prod1000;
  logic [31:0]                prod100;
  logic [31:0]                prod10;
  logic [VALUE_WIDTH-1:0]     digit;
  logic [DATA_WIDTH-1:0]      data_word;
  logic                       conv_last;
  logic                       out_load;

  assign prod1000 = 32'(pop_entry.value) * DIV1000_MULT;
  assign prod100  = 32'(pop_entry.value) * DIV100_MULT;
  assign prod10   = 32'(pop_entry.value) * DIV10_MULT;

  assign conv_last = !conv_entry.display || (idx == DIGIT_IDX_WIDTH'(DIGIT_COUNT - 1));
  assign out_load  = conv_valid && (!out_valid || !out_stall);
  assign pop       = !queue_empty && (!conv_valid || (out_load && conv_last));

  always_comb begin
    case (idx)
      2'd0:    digit = VALUE_WIDTH'(q1000);
      2'd1:    digit = VALUE_WIDTH'(q100) - VALUE_WIDTH'(q1000) * VALUE_WIDTH'(10);
      2'd2:    digit = VALUE_WIDTH'(q10) - VALUE_WIDTH'(q100) * VALUE_WIDTH'(10);
      default: digit = conv_entry.value - VALUE_WIDTH'(q10) * VALUE_WIDTH'(10);
    endcase
    data_word = digit[DATA_WIDTH-1:0];
    if (idx == DIGIT_IDX_WIDTH'(POINT_DIGIT - 1)) begin
      data_word = data_word | POINT_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      conv_entry <= pop_entry;
      q1000      <= prod1000[DIV1000_SHIFT +: Q1000_WIDTH];
      q100       <= prod100[DIV100_SHIFT +: Q100_WIDTH];
      q10        <= prod10[DIV10_SHIFT +: Q10_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (pop) begin
        conv_valid <= 1'b1;
      end else if (out_load && conv_last) begin
        conv_valid <= 1'b0;
      end
      if (out_load) begin
        idx <= conv_last ? '0 : idx + DIGIT_IDX_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      word_valid   <= conv_entry.display;
      digit_select <= conv_entry.display ? SEL_WIDTH'(idx) + SEL_WIDTH'(1) : '0;
      digit_data   <= conv_entry.display ? data_word : '0;
      heater_on    <= conv_entry.heater;
      edit_lamp    <= conv_entry.edit;
      last_word    <= conv_last;
    end
  end

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !word_valid) |-> (last_word && (digit_select == '0)))
    else $error("Status word is not a single last word.");

  a_last_is_units: assert property (@(posedge clk) disable iff (rst)
    (out_valid && word_valid && last_word) |-> (digit_select == SEL_WIDTH'(DIGIT_COUNT)))
    else $error("Display sequence ends before the units digit.");

  a_point_on_tens: assert property (@(posedge clk) disable iff (rst)
    (out_valid && word_valid && (digit_select == SEL_WIDTH'(POINT_DIGIT)))
      |-> digit_data[DATA_WIDTH-1])
    else $error("Decimal point missing on the tens digit.");

endmodule

`default_nettype wire

// ===== design/thermostat_setpoint_panel.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_stall       operation, button_low, encoder_a_low,
//                                               encoder_b_low, temperature
// out      output     out_valid / out_stall     word_valid, digit_select, digit_data,
//                                               heater_on, edit_lamp, last_word
// cfg      input      cfg_write                 cfg_index, cfg_data
//
// A button event that starts a debounce or an encoder event yields four output
// words, one per cycle while out_stall is low; any other event yields one status
// word. The output word register sets this pace. An event is taken every cycle
// while the event queue has room; its words pass the queue slot, the conversion
// register and the output word register. Synchronous reset loads the register
// reset values and the initial set point and empties the queue. A stall on the
// output holds the word; the queue then fills and in_stall rises.
`default_nettype none

module thermostat_setpoint_panel #(
  parameter int unsigned INITIAL_SET_POINT = tsp_pkg::SET_POINT_RESET,
  parameter int unsigned QUEUE_DEPTH       = tsp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tsp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [tsp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tsp_pkg::OP_WIDTH-1:0]         operation,
  input  logic                                 button_low,
  input  logic                                 encoder_a_low,
  input  logic                                 encoder_b_low,
  input  logic [tsp_pkg::TEMP_WIDTH-1:0]       temperature,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 word_valid,
  output logic [tsp_pkg::SEL_WIDTH-1:0]        digit_select,
  output logic [tsp_pkg::DATA_WIDTH-1:0]       digit_data,
  output logic                                 heater_on,
  output logic                                 edit_lamp,
  output logic                                 last_word
);
  import tsp_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   pop;
  entry_t pop_entry;
  logic   queue_empty;

  tsp_front #(
    .INITIAL_SET_POINT(INITIAL_SET_POINT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .button_low   (button_low),
    .encoder_a_low(encoder_a_low),
    .encoder_b_low(encoder_b_low),
    .temperature  (temperature),
    .push         (push),
    .push_entry   (push_entry),
    .queue_full   (queue_full)
  );

  tsp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (queue_full),
    .pop       (pop),
    .pop_entry (pop_entry),
    .empty     (queue_empty)
  );

  tsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_entry   (pop_entry),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .word_valid  (word_valid),
    .digit_select(digit_select),
    .digit_data  (digit_data),
    .heater_on   (heater_on),
    .edit_lamp   (edit_lamp),
    .last_word   (last_word)
  );

endmodule

`default_nettype wire

// ===== test/tb_thermostat_setpoint_panel.sv =====
module tb_thermostat_setpoint_panel;
  import tsp_pkg::*;

  localparam logic [OP_WIDTH-1:0] OP_NONE = 2'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [OP_WIDTH-1:0]   op;
    logic                  button_low;
    logic                  a_low;
    logic                  b_low;
    logic [TEMP_WIDTH-1:0] temperature;
  } panel_event_t;

  typedef struct packed {
    logic                  word_valid;
    logic [SEL_WIDTH-1:0]  digit_select;
    logic [DATA_WIDTH-1:0] digit_data;
    logic                  heater_on;
    logic                  edit_lamp;
    logic                  last_word;
  } panel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_WIDTH-1:0] operation = '0;
  logic button_low = 1'b0;
  logic encoder_a_low = 1'b0;
  logic encoder_b_low = 1'b0;
  logic [TEMP_WIDTH-1:0] temperature = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic word_valid;
  logic [SEL_WIDTH-1:0] digit_select;
  logic [DATA_WIDTH-1:0] digit_data;
  logic heater_on;
  logic edit_lamp;
  logic last_word;

  thermostat_setpoint_panel u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .button_low(button_low),
    .encoder_a_low(encoder_a_low),
    .encoder_b_low(encoder_b_low),
    .temperature(temperature),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_valid(word_valid),
    .digit_select(digit_select),
    .digit_data(digit_data),
    .heater_on(heater_on),
    .edit_lamp(edit_lamp),
    .last_word(last_word)
  );

  // Mirror of the panel state and its registers.
  int cfg_step = STEP_SIZE_RESET;
  int cfg_limit = LIMIT_RESET;
  int cfg_ticks = TICKS_RESET;
  int sp_value = SET_POINT_RESET;
  bit in_edit = 1'b0;
  int db_count = 0;
  bit db_busy = 1'b0;
  bit heater = 1'b0;

  panel_word_t pending_words[$];
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit holding_valid = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver switches between free flow, random stalls and long holds.
  int stall_style = 0;
  int style_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left = $urandom_range(20, 120);
    end else begin
      style_left--;
    end
    case (stall_style)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (hold_left != 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else begin
          if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(3, 12);
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    panel_word_t got_w;
    panel_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      got_w.word_valid = word_valid;
      got_w.digit_select = digit_select;
      got_w.digit_data = digit_data;
      got_w.heater_on = heater_on;
      got_w.edit_lamp = edit_lamp;
      got_w.last_word = last_word;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: valid %0b sel %0d data %h heater %0b edit %0b last %0b",
                   got_w.word_valid, got_w.digit_select, got_w.digit_data,
                   got_w.heater_on, got_w.edit_lamp, got_w.last_word);
      end else begin
        exp_w = pending_words.pop_front();
        if (got_w !== exp_w) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("word mismatch: expected valid %0b sel %0d data %h",
                     exp_w.word_valid, exp_w.digit_select, exp_w.digit_data,
                     " heater %0b edit %0b last %0b,",
                     exp_w.heater_on, exp_w.edit_lamp, exp_w.last_word,
                     " got valid %0b sel %0d data %h",
                     got_w.word_valid, got_w.digit_select, got_w.digit_data,
                     " heater %0b edit %0b last %0b",
                     got_w.heater_on, got_w.edit_lamp, got_w.last_word);
        end
      end
    end
  end

  task automatic push_status();
    panel_word_t w;
    w = '0;
    w.heater_on = heater;
    w.edit_lamp = in_edit;
    w.last_word = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic push_display();
    int place[4] = '{1000, 100, 10, 1};
    int rest;
    int d;
    panel_word_t w;
    if (sp_value > cfg_limit) sp_value = cfg_limit;
    rest = sp_value;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      d = rest / place[k];
      rest = rest % place[k];
      w.word_valid = 1'b1;
      w.digit_select = SEL_WIDTH'(k + 1);
      w.digit_data = DATA_WIDTH'(d);
      if (k + 1 == POINT_DIGIT) w.digit_data = w.digit_data | POINT_BIT;
      w.heater_on = heater;
      w.edit_lamp = in_edit;
      w.last_word = (k == DIGIT_COUNT - 1);
      pending_words.push_back(w);
    end
  endtask

  task automatic predict_event(input panel_event_t ev);
    int s;
    if (ev.op == OP_TICK) begin
      if (db_busy) begin
        if (db_count <= 1) begin
          db_count = 0;
          db_busy = 1'b0;
          if (ev.button_low) begin
            if (in_edit) begin
              in_edit = 1'b0;
              heater = (ev.temperature < sp_value);
            end else begin
              in_edit = 1'b1;
              heater = 1'b0;
            end
          end
        end else begin
          db_count--;
        end
      end
      push_status();
    end else if (ev.op == OP_BUTTON) begin
      if (db_busy) begin
        push_status();
      end else begin
        db_busy = 1'b1;
        db_count = cfg_ticks;
        push_display();
      end
    end else if (ev.op == OP_ENCODER) begin
      if (in_edit) begin
        if (ev.a_low) begin
          if (sp_value > 0) sp_value = (sp_value > cfg_step) ? sp_value - cfg_step : 0;
        end else if (ev.b_low) begin
          if (sp_value < cfg_limit) begin
            s = sp_value + cfg_step;
            sp_value = (s > cfg_limit) ? cfg_limit : s;
          end
        end
      end
      push_display();
    end else begin
      push_status();
    end
  endtask

  // Called at a rising edge; returns at the edge where the event was taken, or after the idle gap that ends a burst.
  task automatic send_event(input panel_event_t ev);
    in_valid <= 1'b1;
    operation <= ev.op;
    button_low <= ev.button_low;
    encoder_a_low <= ev.a_low;
    encoder_b_low <= ev.b_low;
    temperature <= ev.temperature;
    holding_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_event(ev);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      holding_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_op(input logic [OP_WIDTH-1:0] op, input logic btn, input logic a,
                         input logic b, input logic [TEMP_WIDTH-1:0] temp);
    panel_event_t ev;
    ev.op = op;
    ev.button_low = btn;
    ev.a_low = a;
    ev.b_low = b;
    ev.temperature = temp;
    send_event(ev);
  endtask

  function automatic panel_event_t random_event();
    panel_event_t ev;
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) ev.op = OP_TICK;
    else if (r < 55) ev.op = OP_BUTTON;
    else if (r < 93) ev.op = OP_ENCODER;
    else ev.op = OP_NONE;
    ev.button_low = ($urandom_range(0, 3) != 0);
    ev.a_low = ($urandom_range(0, 2) == 0);
    ev.b_low = ($urandom_range(0, 1) != 0);
    case ($urandom_range(0, 9))
      0: ev.temperature = '0;
      1: ev.temperature = 14'd9999;
      2: ev.temperature = '1;
      default: ev.temperature = TEMP_WIDTH'($urandom_range(0, 16383));
    endcase
    return ev;
  endfunction

  task automatic settle_panel();
    if (holding_valid) begin
      in_valid <= 1'b0;
      holding_valid = 1'b0;
    end
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [CFG_DATA_WIDTH-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_STEP_SIZE: cfg_step = value[STEP_WIDTH-1:0];
      REG_SET_POINT_LIMIT: cfg_limit = value[VALUE_WIDTH-1:0];
      REG_DEBOUNCE_TICKS: cfg_ticks = value[TICKS_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // Only while idle; the unused index is written too and must change nothing.
  task automatic program_panel(input int step, input int limit, input int ticks);
    write_register(REG_STEP_SIZE, CFG_DATA_WIDTH'(step));
    write_register(REG_SET_POINT_LIMIT, CFG_DATA_WIDTH'(limit));
    write_register(REG_DEBOUNCE_TICKS, CFG_DATA_WIDTH'(ticks));
    write_register(REG_SPARE, CFG_DATA_WIDTH'($urandom));
    cfg_write <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_op(OP_ENCODER, 1'b0, 1'b0, 1'b1, 14'd500);
    send_op(OP_TICK, 1'b1, 1'b1, 1'b1, 14'd0);
    send_op(OP_NONE, 1'b1, 1'b1, 1'b1, '1);
    settle_panel();
  endtask

  task automatic test_debounce_and_mode();
    program_panel(10, 1000, 0);
    send_op(OP_BUTTON, 1'b1, 1'b0, 1'b0, 14'd100);
    send_op(OP_BUTTON, 1'b1, 1'b0, 1'b0, 14'd100);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b0, 14'd100);
    send_op(OP_ENCODER, 1'b0, 1'b1, 1'b0, 14'd100);
    send_op(OP_ENCODER, 1'b0, 1'b1, 1'b1, 14'd100);
    send_op(OP_ENCODER, 1'b0, 1'b0, 1'b1, 14'd100);
    send_op(OP_ENCODER, 1'b0, 1'b0, 1'b0, 14'd100);
    settle_panel();
  endtask

  task automatic test_set_point_limits();
    program_panel(100, 300, 0);
    repeat (2) send_op(OP_ENCODER, 1'b0, 1'b0, 1'b1, 14'd0);
    repeat (4) send_op(OP_ENCODER, 1'b0, 1'b1, 1'b0, 14'd0);
    settle_panel();
  endtask

  task automatic test_heater_on_exit();
    send_op(OP_ENCODER, 1'b0, 1'b0, 1'b1, 14'd0);
    send_op(OP_BUTTON, 1'b0, 1'b0, 1'b0, 14'd0);
    send_op(OP_TICK, 1'b0, 1'b0, 1'b0, 14'd0);
    send_op(OP_BUTTON, 1'b0, 1'b0, 1'b0, 14'd0);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b0, 14'd0);
    send_op(OP_BUTTON, 1'b0, 1'b0, 1'b0, 14'd0);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b0, 14'd50);
    send_op(OP_BUTTON, 1'b0, 1'b0, 1'b0, 14'd0);
    send_op(OP_TICK, 1'b1, 1'b0, 1'b0, '1);
    settle_panel();
  endtask

  // Climbs past 9999 so the thousands digit goes above nine.
  task automatic test_wide_set_point();
    program_panel(100, 16383, 1);
    while (!in_edit) begin
      if (db_busy)
        send_op(OP_TICK, 1'b1, 1'b0, 1'b0, TEMP_WIDTH'($urandom_range(0, 16383)));
      else
        send_op(OP_BUTTON, 1'b1, 1'b0, 1'b0, TEMP_WIDTH'($urandom_range(0, 16383)));
    end
    while (sp_value < 10500)
      send_op(OP_ENCODER, ($urandom_range(0, 1) != 0), 1'b0, 1'b1,
              TEMP_WIDTH'($urandom_range(0, 16383)));
    settle_panel();
  endtask

  task automatic test_random_traffic(input int step, input int limit, input int ticks,
                                     input int count);
    program_panel(step, limit, ticks);
    repeat (count) send_event(random_event());
    settle_panel();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_debounce_and_mode();
    test_set_point_limits();
    test_heater_on_exit();
    test_wide_set_point();
    test_random_traffic(1, 9999, 3, 35);
    test_random_traffic(57, 0, 1, 20);
    test_random_traffic(100, 1000, 0, 30);
    test_random_traffic(23, 512, 65535, 15);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tsp_pkg.sv
design/tsp_front.sv
design/tsp_queue.sv
design/tsp_back.sv
design/thermostat_setpoint_panel.sv
test/tb_thermostat_setpoint_panel.sv
